@@ design/tlpq_pkg.sv @@
package tlpq_pkg;

    localparam int IdW       = 31;
    localparam int NameLowW  = 64;
    localparam int NameHighW = 56;
    localparam int StatusW   = 3;
    localparam int Levels    = 3;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // result status codes
    localparam logic [StatusW-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [StatusW-1:0] ST_DEQUEUED = 3'd1;
    localparam logic [StatusW-1:0] ST_EMPTY    = 3'd2;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd3;
    localparam logic [StatusW-1:0] ST_BADPRIO  = 3'd4;

    // priority code that no level serves
    localparam logic [1:0] PRIO_NONE = 2'd0;

    // transaction as it travels along the chain of level cells
    typedef struct packed {
        logic                 func;
        logic [1:0]           prio;
        logic                 done;
        logic [StatusW-1:0]   status;
        logic [IdW-1:0]       id;
        logic [NameLowW-1:0]  name_low;
        logic [NameHighW-1:0] name_high;
    } req_t;

endpackage

@@ design/tlpq_cell.sv @@
module tlpq_cell #(
    parameter int         ENTRIES = 16,
    parameter logic [1:0] LEVEL   = 2'd3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  tlpq_pkg::req_t in_req,
    output logic           out_valid,
    output tlpq_pkg::req_t out_req
);
    import tlpq_pkg::*;

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CntW = $clog2(ENTRIES + 1);
    localparam int SumW = CntW + 1;
    localparam logic [CntW-1:0] Full    = CntW'(ENTRIES);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
    localparam logic [SumW-1:0] Wrap    = SumW'(ENTRIES);

    logic [CntW-1:0] count_reg;
    logic [IdxW-1:0] head_reg;
    logic            valid_reg;
    req_t            req_reg;
    logic            hit_reg;
    logic [IdW-1:0]       rd_id_reg;
    logic [NameLowW-1:0]  rd_low_reg;
    logic [NameHighW-1:0] rd_high_reg;

    logic [IdW-1:0]       mem_id   [ENTRIES];
    logic [NameLowW-1:0]  mem_low  [ENTRIES];
    logic [NameHighW-1:0] mem_high [ENTRIES];

    logic            mine;
    logic            enq_hit;
    logic            wr_en;
    logic            full_hit;
    logic            deq_hit;
    logic [SumW-1:0] sum;
    logic [SumW-1:0] tail_wide;
    logic [IdxW-1:0] tail_idx;
    logic [IdxW-1:0] head_inc;
    req_t            req_next;

    // decide what this level does with the passing transaction
    always_comb begin
        mine      = (in_req.func == FUNC_ENQ) && (in_req.prio == LEVEL);
        enq_hit   = in_valid && !in_req.done && mine;
        wr_en     = enq_hit && (count_reg != Full);
        full_hit  = enq_hit && (count_reg == Full);
        deq_hit   = in_valid && !in_req.done && (in_req.func == FUNC_DEQ) &&
                    (count_reg != '0);
        sum       = SumW'(head_reg) + SumW'(count_reg);
        tail_wide = (sum >= Wrap) ? (sum - Wrap) : sum;
        tail_idx  = tail_wide[IdxW-1:0];
        head_inc  = (head_reg == LastIdx) ? '0 : (head_reg + 1'b1);
        req_next  = in_req;
        priority if (wr_en) begin
            req_next.done   = 1'b1;
            req_next.status = ST_ENQUEUED;
        end else if (full_hit) begin
            req_next.done   = 1'b1;
            req_next.status = ST_FULL;
        end else if (deq_hit) begin
            req_next.done   = 1'b1;
            req_next.status = ST_DEQUEUED;
        end
    end

    // level bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            head_reg  <= '0;
        end else if (adv) begin
            valid_reg <= in_valid;
            if (wr_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (deq_hit) begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_inc;
            end
        end
    end

    // entry storage and hand-off to the next cell
    always_ff @(posedge aclk) begin
        if (adv) begin
            req_reg     <= req_next;
            hit_reg     <= deq_hit;
            rd_id_reg   <= mem_id[head_reg];
            rd_low_reg  <= mem_low[head_reg];
            rd_high_reg <= mem_high[head_reg];
            if (wr_en) begin
                mem_id[tail_idx]   <= in_req.id;
                mem_low[tail_idx]  <= in_req.name_low;
                mem_high[tail_idx] <= in_req.name_high;
            end
        end
    end

    // dequeued entry replaces the payload
    always_comb begin
        out_req = req_reg;
        if (hit_reg) begin
            out_req.id        = rd_id_reg;
            out_req.name_low  = rd_low_reg;
            out_req.name_high = rd_high_reg;
        end
    end

    assign out_valid = valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Full)
        else $error("level count above capacity");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && wr_en) |=> (count_reg == CntW'($past(count_reg) + 1'b1)))
        else $error("enqueue did not grow the level");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && deq_hit) |=> (count_reg == CntW'($past(count_reg) - 1'b1)) &&
                             (head_reg == $past(head_inc)))
        else $error("dequeue did not shrink the level");

endmodule

@@ design/three_level_priority_queue_core.sv @@
// Strict-priority queue with three levels (3 highest), each a circular
// buffer of ENTRIES_PER_LEVEL entries of a 31-bit id and a NAME_BYTES-byte
// name. A transaction with func 0 enqueues at the tail of its level (status
// 0, or 3 when the level is full, or 4 for priority 0); func 1 dequeues the
// oldest entry of the highest non-empty level (status 1) or reports empty
// (status 2). Id and name outputs are zero unless an entry was dequeued.
// The transaction walks a chain of three level cells, level 3 first, one
// cell per cycle, each cell owning its level's head, count and storage:
// one transaction is accepted every cycle and its result comes from the last
// cell's register; back-pressure on the result channel stalls the chain.
module three_level_priority_queue_core #(
    parameter int ENTRIES_PER_LEVEL = 16,
    parameter int NAME_BYTES        = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [1:0]                         s_priority_req,
    input  logic [tlpq_pkg::IdW-1:0]           s_entry_id,
    input  logic [tlpq_pkg::NameLowW-1:0]      s_name_low,
    input  logic [tlpq_pkg::NameHighW-1:0]     s_name_high,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tlpq_pkg::StatusW-1:0]       m_status,
    output logic [tlpq_pkg::IdW-1:0]           m_out_id,
    output logic [tlpq_pkg::NameLowW-1:0]      m_out_name_low,
    output logic [tlpq_pkg::NameHighW-1:0]     m_out_name_high
);
    import tlpq_pkg::*;

    function automatic logic [NameLowW-1:0] low_mask_f();
        logic [NameLowW-1:0] m;
        for (int b = 0; b < NameLowW; b++) begin
            m[b] = ((b / 8) < NAME_BYTES);
        end
        return m;
    endfunction

    function automatic logic [NameHighW-1:0] high_mask_f();
        logic [NameHighW-1:0] m;
        for (int b = 0; b < NameHighW; b++) begin
            m[b] = ((b / 8) + 8 < NAME_BYTES);
        end
        return m;
    endfunction

    localparam logic [NameLowW-1:0]  LowMask  = low_mask_f();
    localparam logic [NameHighW-1:0] HighMask = high_mask_f();

    logic adv;
    logic chain_valid [Levels+1];
    req_t chain_req   [Levels+1];
    req_t last_req;
    logic deq_out;

    // whole chain moves when the result slot is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // incoming transaction, priority zero settled before the chain
    always_comb begin
        chain_valid[0]         = s_valid;
        chain_req[0].func      = s_func;
        chain_req[0].prio      = s_priority_req;
        chain_req[0].done      = (s_func == FUNC_ENQ) && (s_priority_req == PRIO_NONE);
        chain_req[0].status    = ST_BADPRIO;
        chain_req[0].id        = s_entry_id;
        chain_req[0].name_low  = s_name_low & LowMask;
        chain_req[0].name_high = s_name_high & HighMask;
    end

    // one cell per level, highest level first
    for (genvar i = 0; i < Levels; i++) begin : g_level
        tlpq_cell #(
            .ENTRIES (ENTRIES_PER_LEVEL),
            .LEVEL   (2'(Levels - i))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_req    (chain_req[i]),
            .out_valid (chain_valid[i+1]),
            .out_req   (chain_req[i+1])
        );
    end

    // result; an unclaimed transaction can only be a dequeue on an empty queue
    always_comb begin
        last_req        = chain_req[Levels];
        m_valid         = chain_valid[Levels];
        m_status        = last_req.done ? last_req.status : ST_EMPTY;
        deq_out         = (m_status == ST_DEQUEUED);
        m_out_id        = deq_out ? last_req.id : '0;
        m_out_name_low  = deq_out ? last_req.name_low : '0;
        m_out_name_high = deq_out ? last_req.name_high : '0;
    end

    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_DEQUEUED)) |->
            ((m_out_id == '0) && (m_out_name_low == '0) && (m_out_name_high == '0)))
        else $error("payload not zero on a non-dequeue result");

endmodule
